// File: rtl/core/ccdse_pkg.sv
// Package for the character/colour delta skip encoder.
// Holds the command record passed from front to back, sizes and register codes.
// No dependencies.
`default_nettype none

package ccdse_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;
  localparam int unsigned SeqW    = 5;

  localparam logic [ByteW-1:0] RunLimit   = 8'd254;
  localparam logic [ByteW-1:0] NibbleMask = 8'h0F;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SKIP_TOKEN = 1'b0,
    CFG_END_TOKEN  = 1'b1
  } cfg_idx_e;

  // Bit positions in the byte sequence mask, in emission order
  localparam int unsigned SeqSkipMark = 0;
  localparam int unsigned SeqSkipCnt  = 1;
  localparam int unsigned SeqColour   = 2;
  localparam int unsigned SeqChar     = 3;
  localparam int unsigned SeqEnd      = 4;

  // One classified cell: which bytes to send and their values
  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [ByteW-1:0] marker;
    logic [ByteW-1:0] count;
    logic [NibW-1:0]  colour;
    logic [ByteW-1:0] chr;
    logic [ByteW-1:0] end_tok;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/ccdse_front.sv
// Front end of the delta skip encoder: accepts cells, keeps the skip run count
// and classifies each cell into a command. Depends on ccdse_pkg.
`default_nettype none

module ccdse_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ccdse_pkg::ByteW-1:0]  prev_char_i,
  input  wire logic [ccdse_pkg::ByteW-1:0]  new_char_i,
  input  wire logic [ccdse_pkg::ByteW-1:0]  prev_colour_i,
  input  wire logic [ccdse_pkg::ByteW-1:0]  new_colour_i,
  input  wire logic                         last_cell_i,
  input  wire logic [ccdse_pkg::ByteW-1:0]  skip_token_i,
  input  wire logic [ccdse_pkg::ByteW-1:0]  end_token_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output ccdse_pkg::cmd_t                   cmd_o
);

  logic [ccdse_pkg::ByteW-1:0] run_q, run_d;
  logic [ccdse_pkg::NibW-1:0]  nc;
  logic                        changed, at_limit, accept;

  assign nc       = new_colour_i[ccdse_pkg::NibW-1:0];
  assign changed  = (prev_char_i != new_char_i) ||
                    (prev_colour_i[ccdse_pkg::NibW-1:0] != nc);
  assign at_limit = (run_q == ccdse_pkg::RunLimit);

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.seq[ccdse_pkg::SeqSkipMark] = changed ? (run_q != '0) : at_limit;
    cmd_o.seq[ccdse_pkg::SeqSkipCnt]  = changed ? (run_q != '0) : at_limit;
    cmd_o.seq[ccdse_pkg::SeqColour]   = changed;
    cmd_o.seq[ccdse_pkg::SeqChar]     = changed;
    cmd_o.seq[ccdse_pkg::SeqEnd]      = last_cell_i;
    cmd_o.marker  = skip_token_i | (new_colour_i & ccdse_pkg::NibbleMask);
    cmd_o.count   = run_q;
    cmd_o.colour  = nc;
    cmd_o.chr     = new_char_i;
    cmd_o.end_tok = end_token_i;
  end

  // Drop cells that only extend the run
  assign push_o = accept && (cmd_o.seq != '0);

  always_comb begin
    run_d = run_q;
    if (accept) begin
      if (last_cell_i || changed || at_limit) begin
        run_d = '0;
      end else begin
        run_d = run_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ccdse_queue.sv
// Two-entry command queue between front and back of the delta skip encoder.
// Depends on ccdse_pkg.
`default_nettype none

module ccdse_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ccdse_pkg::cmd_t cmd_i,
  input  wire logic            pop_i,
  output ccdse_pkg::cmd_t      head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  ccdse_pkg::cmd_t               mem_q [ccdse_pkg::QDepth];
  logic [ccdse_pkg::QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [ccdse_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == ccdse_pkg::QCntW'(ccdse_pkg::QDepth));
  assign head_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ccdse_back.sv
// Back end of the delta skip encoder: walks the bytes of the head command
// into a registered one-byte output stage. Depends on ccdse_pkg.
`default_nettype none

module ccdse_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ccdse_pkg::cmd_t              head_i,
  input  wire logic                         empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ccdse_pkg::ByteW-1:0]       out_byte_o,
  output logic                              out_last_o
);

  logic                        busy_q, busy_d;
  logic [ccdse_pkg::SeqW-1:0]  rem_q, rem_d;
  logic                        vld_q, vld_d;
  logic [ccdse_pkg::ByteW-1:0] byte_q, byte_d;
  logic                        last_q, last_d;

  logic [ccdse_pkg::SeqW-1:0]  cur_mask, pick;
  logic [ccdse_pkg::ByteW-1:0] sel_byte;
  logic                        can_load, emit, is_last;

  assign cur_mask = busy_q ? rem_q : head_i.seq;
  assign pick     = cur_mask & (~cur_mask + 5'd1);
  assign is_last  = ((cur_mask & ~pick) == '0);
  assign can_load = !vld_q || out_ready_i;
  assign emit     = can_load && !empty_i;
  assign pop_o    = emit && is_last;

  always_comb begin
    priority if (cur_mask[ccdse_pkg::SeqSkipMark]) begin
      sel_byte = head_i.marker;
    end else if (cur_mask[ccdse_pkg::SeqSkipCnt]) begin
      sel_byte = head_i.count;
    end else if (cur_mask[ccdse_pkg::SeqColour]) begin
      sel_byte = {{(ccdse_pkg::ByteW-ccdse_pkg::NibW){1'b0}}, head_i.colour};
    end else if (cur_mask[ccdse_pkg::SeqChar]) begin
      sel_byte = head_i.chr;
    end else begin
      sel_byte = head_i.end_tok;
    end
  end

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    if (can_load) begin
      vld_d = emit;
    end
    if (emit) begin
      byte_d = sel_byte;
      last_d = is_last;
      busy_d = !is_last;
      rem_d  = cur_mask & ~pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// File: rtl/core/char_color_delta_skip_encoder.sv
// Top level of the character/colour delta skip encoder.
// Instantiates ccdse_front, ccdse_queue and ccdse_back; uses ccdse_pkg.
//
//   channel   direction  signals                         beat carries
//   s_axis    in         s_axis_tvalid/tready/tdata/tlast one screen cell
//   m_axis    out        m_axis_tvalid/tready/tdata/tlast one stream byte
//   cfg       in         cfg_valid/ready/index/data      one register write
//
// A cell is taken whenever the queue is not full; the back end sends one
// byte per cycle while the output is ready and a command is queued. A cell
// causes none to five bytes (two for a typical changed cell); a cell with
// none is still taken. The single-byte output register sets the sustained rate.
// Reset clears the run count, queue and output valid; both tokens reset to 0.
// The two-entry queue lets the front keep taking cells while the back stalls.
`default_nettype none

module char_color_delta_skip_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: prev_char[7:0], new_char[15:8], prev_color[23:16], new_color[31:24]
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,  // last_cell
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: out_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,  // last_of_run
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic [ccdse_pkg::ByteW-1:0] skip_token_q, end_token_q;
  logic                        push, pop, q_empty, q_full;
  ccdse_pkg::cmd_t             push_cmd, head_cmd;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_token_q <= '0;
      end_token_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (ccdse_pkg::cfg_idx_e'(cfg_index_i))
        ccdse_pkg::CFG_SKIP_TOKEN: skip_token_q <= cfg_data_i;
        ccdse_pkg::CFG_END_TOKEN:  end_token_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the cell and advance the skip run
  ccdse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .prev_char_i   (s_axis_tdata[7:0]),
    .new_char_i    (s_axis_tdata[15:8]),
    .prev_colour_i (s_axis_tdata[23:16]),
    .new_colour_i  (s_axis_tdata[31:24]),
    .last_cell_i   (s_axis_tlast),
    .skip_token_i  (skip_token_q),
    .end_token_i   (end_token_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // Hold pending commands between front and back
  ccdse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Serialise each command into bytes
  ccdse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for char_color_delta_skip_encoder: screen cells in, encoded bytes out.
// Predicts every output byte from its own copy of the run count and tokens.
// Depends on ccdse_pkg and the encoder RTL; no files or arguments are read.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccdse_pkg::*;

  localparam int unsigned SettleCycles     = 16;
  localparam int unsigned IdleLimit        = 5000;
  localparam int unsigned SegmentsPerPhase = 7;
  localparam int unsigned DrainEvery       = 150;

  // One screen cell as it travels on the input stream
  typedef struct packed {
    logic [7:0] prev_char;
    logic [7:0] new_char;
    logic [7:0] prev_color;
    logic [7:0] new_color;
    logic       last;
  } cell_t;

  // One byte of the encoded stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // How a random segment of cells finishes after its unchanged run
  typedef enum int unsigned {
    TAIL_CHANGED,
    TAIL_SAME_LAST,
    TAIL_NOISE
  } tail_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_SKIP_TOKEN;
  logic [7:0]  cfg_data = '0;

  // Predictor state: mirrors the block's run count and its two tokens
  logic [7:0] run_len = '0;
  logic [7:0] skip_base = '0;
  logic [7:0] end_byte = '0;

  cell_t        cell_queue [$];     // cells waiting to be driven
  stream_byte_t pending_bytes [$];  // bytes predicted but not yet seen
  cell_t        cur_cell;
  int unsigned  fail_count = 0;
  int unsigned  cells_sent = 0;
  int unsigned  cells_taken = 0;
  int unsigned  tx_gap = 0;
  int unsigned  tx_calm = 0;
  bit           tx_drain = 1'b0;
  int unsigned  rx_stall = 0;
  int unsigned  rx_calm = 0;

  char_color_delta_skip_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Encode one accepted cell and queue the bytes it must produce. A cell is
  // unchanged when the characters match and the low colour nibbles match;
  // the upper colour bits never matter.
  function automatic void encode_cell(cell_t c);
    logic [7:0] nib;
    logic [7:0] seq [5];
    int         n;
    stream_byte_t b;
    nib = c.new_color & NibbleMask;
    n = 0;
    if (c.prev_char == c.new_char && (c.prev_color & NibbleMask) == nib) begin
      if (run_len < RunLimit) begin
        run_len = run_len + 8'd1;
      end else begin
        // full run: flush it now, this cell itself is not counted
        seq[n] = skip_base | nib;
        n++;
        seq[n] = run_len;
        n++;
        run_len = '0;
      end
    end else begin
      if (run_len != 8'd0) begin
        seq[n] = skip_base | nib;
        n++;
        seq[n] = run_len;
        n++;
        run_len = '0;
      end
      seq[n] = nib;
      n++;
      seq[n] = c.new_char;
      n++;
    end
    // end of frame: append the end token and drop any pending run
    if (c.last) begin
      seq[n] = end_byte;
      n++;
      run_len = '0;
    end
    for (int i = 0; i < n; i++) begin
      b.data = seq[i];
      b.last = (i == n - 1);
      pending_bytes.push_back(b);
    end
  endfunction

  // Mostly no gap or a short one, now and then a long one, and at random a
  // calm stretch with no gaps at all.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    case ($urandom_range(0, 15))
      0: return $urandom_range(10, 40);
      1, 2, 3, 4, 5: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  function automatic void add_cell(logic [7:0] pch, logic [7:0] nch, logic [7:0] pcol,
                                   logic [7:0] ncol, logic last);
    cell_t c;
    c.prev_char = pch;
    c.new_char = nch;
    c.prev_color = pcol;
    c.new_color = ncol;
    c.last = last;
    cell_queue.push_back(c);
  endfunction

  // Unchanged cell with random content; upper colour nibbles differ freely
  function automatic cell_t same_cell(logic last);
    cell_t c;
    c.prev_char = 8'($urandom);
    c.new_char = c.prev_char;
    c.prev_color = 8'($urandom);
    c.new_color = {4'($urandom), c.prev_color[3:0]};
    c.last = last;
    return c;
  endfunction

  // Changed cell: colour nibble only, character only, or both
  function automatic cell_t changed_cell(logic last);
    cell_t c;
    c = same_cell(last);
    case ($urandom_range(0, 2))
      0: c.new_color[3:0] = c.prev_color[3:0] ^ 4'($urandom_range(1, 15));
      1: c.new_char = c.prev_char ^ 8'($urandom_range(1, 255));
      default: begin
        c.new_color[3:0] = c.prev_color[3:0] ^ 4'($urandom_range(1, 15));
        c.new_char = c.prev_char ^ 8'($urandom_range(1, 255));
      end
    endcase
    return c;
  endfunction

  function automatic cell_t noise_cell();
    cell_t c;
    {c.prev_char, c.new_char, c.prev_color, c.new_color} = $urandom;
    c.last = ($urandom_range(0, 9) == 0);
    return c;
  endfunction

  function automatic void queue_segment(int unsigned run, tail_e tail);
    for (int unsigned i = 0; i < run; i++) cell_queue.push_back(same_cell(1'b0));
    case (tail)
      TAIL_CHANGED: cell_queue.push_back(changed_cell($urandom_range(0, 9) == 0));
      TAIL_SAME_LAST: cell_queue.push_back(same_cell(1'b1));
      default: cell_queue.push_back(noise_cell());
    endcase
  endfunction

  // One random phase: runs of unchanged cells closed by a changed cell, an
  // unchanged end-of-frame cell or plain noise. In the first phase one run
  // reaches the limit; in the third a longer run is flushed by a change.
  function automatic void queue_phase(int phase);
    int unsigned run;
    int unsigned pick;
    tail_e       tail;
    for (int s = 0; s < SegmentsPerPhase; s++) begin
      pick = $urandom_range(0, 99);
      tail = (pick < 78) ? TAIL_CHANGED : (pick < 88) ? TAIL_SAME_LAST : TAIL_NOISE;
      if (phase == 0 && s == 1) begin
        run = RunLimit;
        tail = TAIL_SAME_LAST;
      end else if (phase == 2 && s == 1) begin
        run = $urandom_range(8, 24);
        tail = TAIL_CHANGED;
      end else begin
        run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      queue_segment(run, tail);
    end
  endfunction

  // Register write; the predictor takes the value at the handshake
  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SKIP_TOKEN: skip_base = val;
      CFG_END_TOKEN: end_byte = val;
      default: ;
    endcase
  endtask

  // Wait until every cell is in and every predicted byte is out, then let
  // the block settle, since a trailing cell may produce no byte at all.
  task automatic wait_drained();
    int unsigned idle;
    idle = 0;
    while ((cell_queue.size() != 0 || cells_taken != cells_sent ||
            pending_bytes.size() != 0) && idle < IdleLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    if (cell_queue.size() != 0 || cells_taken != cells_sent ||
        pending_bytes.size() != 0) begin
      $display("%0t: stream stalled, %0d cells unsent, %0d bytes still expected",
               $time, cell_queue.size(), pending_bytes.size());
      fail_count++;
      cell_queue.delete();
      pending_bytes.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Input driver: hold the beat while the block stalls, predict on
  // acceptance, then idle, drain or advance to the next cell.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        encode_cell(cur_cell);
        cells_taken++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (tx_drain && pending_bytes.size() != 0) begin
          s_tvalid <= 1'b0;
        end else if (cell_queue.size() == 0) begin
          tx_drain = 1'b0;
          s_tvalid <= 1'b0;
        end else begin
          tx_drain = 1'b0;
          cur_cell = cell_queue.pop_front();
          s_tdata <= {cur_cell.new_color, cur_cell.prev_color,
                      cur_cell.new_char, cur_cell.prev_char};
          s_tlast <= cur_cell.last;
          s_tvalid <= 1'b1;
          cells_sent++;
          tx_gap = pick_gap(tx_calm);
          // now and then hold off until the whole output has drained
          if (cells_sent % DrainEvery == DrainEvery / 2) tx_drain = 1'b1;
        end
      end
    end
  end

  // Output monitor: check each beat against the oldest prediction and
  // stall the output side at random.
  always @(posedge clk_i) begin
    stream_byte_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got %02h last %0b",
                   $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want.data, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                     $time, want.last, m_tlast);
            fail_count++;
          end
        end
      end
      if (rx_stall != 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    logic [7:0] skip_val;
    logic [7:0] end_val;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, tokens still at their reset value of zero
    add_cell(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);  // extremes, changed
    add_cell(8'hFF, 8'h00, 8'h00, 8'h0F, 1'b0);
    add_cell(8'hA5, 8'hA5, 8'h3C, 8'hFC, 1'b0);  // only upper colour bits differ
    add_cell(8'hA5, 8'hA5, 8'h31, 8'h32, 1'b0);  // colour nibble change flushes run
    wait_drained();

    write_reg(CFG_SKIP_TOKEN, 8'hE0);
    write_reg(CFG_END_TOKEN, 8'h7E);
    add_cell(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_cell(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_cell(8'h10, 8'h11, 8'h47, 8'h47, 1'b0);  // character change, run of two
    add_cell(8'h20, 8'h21, 8'h05, 8'h06, 1'b1);  // changed last cell, no run
    add_cell(8'h33, 8'h33, 8'h5A, 8'hAA, 1'b0);
    add_cell(8'h33, 8'h33, 8'h5A, 8'hAA, 1'b0);
    add_cell(8'h33, 8'h33, 8'h5A, 8'hAA, 1'b1);  // run dropped at end of frame
    add_cell(8'h44, 8'h44, 8'h01, 8'h01, 1'b1);  // unchanged last, empty run
    add_cell(8'h55, 8'h55, 8'h02, 8'h02, 1'b0);
    add_cell(8'h55, 8'h56, 8'h02, 8'h03, 1'b1);  // run flush, cell, end: five bytes
    add_cell(8'hFF, 8'h00, 8'hF0, 8'h0F, 1'b1);
    wait_drained();

    write_reg(CFG_SKIP_TOKEN, 8'hFF);
    write_reg(CFG_END_TOKEN, 8'h00);
    add_cell(8'h66, 8'h66, 8'h09, 8'h09, 1'b0);
    add_cell(8'h66, 8'h67, 8'h09, 8'h09, 1'b0);
    wait_drained();

    // Random phases, each under its own pair of tokens
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          skip_val = 8'h00;
          end_val = 8'hFF;
        end
        1: begin
          skip_val = 8'hFF;
          end_val = 8'h00;
        end
        2: begin
          skip_val = 8'($urandom);
          end_val = 8'($urandom);
        end
        default: begin
          skip_val = 8'h0F;
          end_val = 8'hF0;
        end
      endcase
      write_reg(CFG_SKIP_TOKEN, skip_val);
      write_reg(CFG_END_TOKEN, end_val);
      queue_phase(p);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ccdse_pkg.sv
rtl/core/ccdse_front.sv
rtl/core/ccdse_queue.sv
rtl/core/ccdse_back.sv
rtl/core/char_color_delta_skip_encoder.sv
tb/tb_top.sv
